// ===== hw/rtl/chti_pkg.sv =====
`default_nettype none

package chti_pkg;

    // Operation codes carried in the opcode field of an input beat.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_FAILED  = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NUM_CHOICES  = 2'd0;
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd1;
    localparam logic [1:0] CFG_RANDOM_SEED  = 2'd2;

    // Configuration reset values.
    localparam logic [2:0]  NUM_CHOICES_RST  = 3'd3;
    localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd100;
    localparam logic [31:0] RANDOM_SEED_RST  = 32'd1;

    // Galois LFSR feedback mask (right shift).
    localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;

    // Four 8-bit bucket choices packed into one word, choice_a lowest.
    localparam int CHOICE_SLOTS = 4;
    localparam int CHOICE_W     = 32;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key_in;
        logic [7:0]  choice_a;
        logic [7:0]  choice_b;
        logic [7:0]  choice_c;
        logic [7:0]  choice_d;
        logic [7:0]  read_slot;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic        slot_occupied;
        logic [31:0] slot_key;
        logic        batch_failed;
        logic [7:0]  displacements;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== hw/rtl/cuckoo_hash_table_insert.sv =====
`default_nettype none

// Cuckoo hash table insert engine.
// Input channel (i_in_valid / o_in_ready, payload i_in_beat) takes one operation
// at a time: insert a key with its pre-hashed bucket choices, read one slot, or
// clear the table. Each operation except the unused opcode returns one result
// beat on the output channel (o_out_valid / i_out_ready, payload o_out_beat).
// The table lives in one single-port-write memory with a registered read port.
// An insert runs an attempt state, then probes its candidates in order, at most
// the choice count, and enters an evict state when all of them are full; each
// eviction starts a new attempt, up to max_attempts. A clear sweeps every slot,
// and a read does one memory read. The memory read port is used once per probe.
// After reset the engine sweeps the memory to mark every slot empty and accepts
// no operation meanwhile; configuration writes are taken.
// Results sit in an output register, so a new operation is accepted while the
// previous result waits. When the receiver stalls and the register is still
// full, the engine holds its finished operation until the register frees up.
module cuckoo_hash_table_insert
    import chti_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 32,
    parameter int MAX_CHOICES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_beat    i_in_beat,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_beat        o_out_beat
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic                valid;
        logic [CHOICE_W-1:0] choices;
        logic [KEY_BITS-1:0] key;
    } t_slot_word;

    typedef enum logic [5:0] {
        S_SWEEP   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_READ    = 6'b000100,
        S_ATTEMPT = 6'b001000,
        S_PROBE   = 6'b010000,
        S_EVICT   = 6'b100000
    } t_state;

    // Bucket index of an 8-bit choice, reduced modulo the table depth.
    typedef logic [IDX_W-1:0] t_mod_lut [256];

    function automatic t_mod_lut f_build_lut();
        t_mod_lut lut;
        for (int k = 0; k < 256; k++) begin
            lut[k] = IDX_W'(k % TABLE_DEPTH);
        end
        return lut;
    endfunction

    localparam t_mod_lut SLOT_LUT = f_build_lut();

    // Residue of a 32-bit value modulo 3: base-4 digits each weigh 1 mod 3.
    function automatic logic [1:0] f_mod3(input logic [31:0] s);
        logic [5:0] acc;
        logic [3:0] t;
        acc = '0;
        for (int k = 0; k < 16; k++) begin
            acc = acc + 6'(s[2*k +: 2]);
        end
        t = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]);
        if (t >= 4'd6) begin
            t = t - 4'd6;
        end else if (t >= 4'd3) begin
            t = t - 4'd3;
        end
        return t[1:0];
    endfunction

    // Which candidate to evict: LFSR value modulo the choice count.
    function automatic logic [1:0] f_pick(input logic [31:0] s, input logic [2:0] n);
        logic [1:0] r;
        case (n)
            3'd2:    r = {1'b0, s[0]};
            3'd3:    r = f_mod3(s);
            3'd4:    r = s[1:0];
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Control and configuration registers.
    t_state           r_state, n_state;
    logic [2:0]       r_num_choices;
    logic [7:0]       r_max_attempts;
    logic [31:0]      r_lfsr, n_lfsr;
    logic             r_failed, n_failed;
    logic [IDX_W-1:0] r_sweep_idx, n_sweep_idx;
    logic             r_clr_reply, n_clr_reply;
    logic             r_out_vld;

    // Per-insert working registers.
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CHOICE_W-1:0] r_choices, n_choices;
    logic [7:0]          r_attempt, n_attempt;
    logic [1:0]          r_ci, n_ci;
    logic [KEY_BITS-1:0] r_old_key [CHOICE_SLOTS];
    logic [CHOICE_W-1:0] r_old_ch  [CHOICE_SLOTS];
    logic                w_save_old;
    t_out_beat           r_out, n_out;
    logic                w_out_load;

    // Table memory.
    t_slot_word          r_mem [TABLE_DEPTH];
    t_slot_word          r_mem_q;
    logic                w_mem_we;
    logic [IDX_W-1:0]    w_mem_waddr;
    t_slot_word          w_mem_wdata;
    logic                w_mem_re;
    logic [IDX_W-1:0]    w_mem_raddr;

    // Helper values.
    logic [2:0]       w_n_eff;
    logic             w_out_free;
    logic             w_in_acc;
    logic [1:0]       w_next_ci;
    logic             w_last;
    logic [31:0]      w_lfsr_nx;
    logic [1:0]       w_pick;
    logic [IDX_W-1:0] w_cand_slot;
    logic [IDX_W-1:0] w_next_slot;
    logic [IDX_W-1:0] w_pick_slot;

    // Effective choice count: zero acts as one, large values saturate.
    always_comb begin
        if (r_num_choices == 3'd0) begin
            w_n_eff = 3'd1;
        end else if (r_num_choices > 3'(MAX_CHOICES)) begin
            w_n_eff = 3'(MAX_CHOICES);
        end else begin
            w_n_eff = r_num_choices;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_next_ci   = r_ci + 2'd1;
    assign w_last      = ({1'b0, r_ci} == (w_n_eff - 3'd1));
    assign w_lfsr_nx   = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);
    assign w_pick      = f_pick(w_lfsr_nx, w_n_eff);
    assign w_cand_slot = SLOT_LUT[r_choices[{r_ci, 3'b000} +: 8]];
    assign w_next_slot = SLOT_LUT[r_choices[{w_next_ci, 3'b000} +: 8]];
    assign w_pick_slot = SLOT_LUT[r_choices[{w_pick, 3'b000} +: 8]];

    // Sequencer: sweeps the table, serves reads, probes candidates in order, evicts on a full set, replies.
    always_comb begin
        n_state     = r_state;
        n_lfsr      = r_lfsr;
        n_failed    = r_failed;
        n_sweep_idx = r_sweep_idx;
        n_clr_reply = r_clr_reply;
        n_key       = r_key;
        n_choices   = r_choices;
        n_attempt   = r_attempt;
        n_ci        = r_ci;
        n_out       = r_out;
        w_out_load  = 1'b0;
        w_save_old  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = w_cand_slot;
        w_mem_wdata = '{valid: 1'b1, choices: r_choices, key: r_key};
        w_mem_re    = 1'b0;
        w_mem_raddr = w_cand_slot;

        case (r_state)
            S_SWEEP: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_sweep_idx;
                w_mem_wdata = '0;
                if (r_sweep_idx != LAST_IDX) begin
                    n_sweep_idx = r_sweep_idx + 1'b1;
                end else if (!r_clr_reply) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_out_load  = 1'b1;
                    n_out       = '{status: ST_CLEARED, slot_occupied: 1'b0,
                                    slot_key: 32'd0, batch_failed: 1'b0,
                                    displacements: 8'd0};
                    n_clr_reply = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_beat.opcode)
                        OP_INSERT: begin
                            n_key     = KEY_BITS'(i_in_beat.key_in);
                            n_choices = {i_in_beat.choice_d, i_in_beat.choice_c,
                                         i_in_beat.choice_b, i_in_beat.choice_a};
                            n_attempt = 8'd0;
                            n_ci      = 2'd0;
                            n_state   = S_ATTEMPT;
                        end
                        OP_READ: begin
                            w_mem_re    = 1'b1;
                            w_mem_raddr = SLOT_LUT[i_in_beat.read_slot];
                            n_state     = S_READ;
                        end
                        OP_CLEAR: begin
                            n_failed    = 1'b0;
                            n_sweep_idx = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_SWEEP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_out      = '{status: ST_READ, slot_occupied: r_mem_q.valid,
                                   slot_key: r_mem_q.valid ? 32'(r_mem_q.key) : 32'd0,
                                   batch_failed: r_failed, displacements: 8'd0};
                    n_state    = S_IDLE;
                end
            end

            S_ATTEMPT: begin
                if (r_attempt >= r_max_attempts) begin
                    // Eviction limit reached: the key in hand is dropped.
                    if (w_out_free) begin
                        w_out_load = 1'b1;
                        n_out      = '{status: ST_FAILED, slot_occupied: 1'b0,
                                       slot_key: 32'd0, batch_failed: 1'b1,
                                       displacements: r_attempt};
                        n_failed   = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    w_mem_re    = 1'b1;
                    w_mem_raddr = w_cand_slot;
                    n_state     = S_PROBE;
                end
            end

            S_PROBE: begin
                if (!r_mem_q.valid) begin
                    // Empty candidate: place the key and reply.
                    if (w_out_free) begin
                        w_mem_we    = 1'b1;
                        w_mem_waddr = w_cand_slot;
                        w_out_load  = 1'b1;
                        n_out       = '{status: ST_PLACED, slot_occupied: 1'b0,
                                        slot_key: 32'd0, batch_failed: r_failed,
                                        displacements: r_attempt};
                        n_state     = S_IDLE;
                    end
                end else begin
                    w_save_old = 1'b1;
                    if (w_last) begin
                        n_state = S_EVICT;
                    end else begin
                        n_ci        = w_next_ci;
                        w_mem_re    = 1'b1;
                        w_mem_raddr = w_next_slot;
                    end
                end
            end

            S_EVICT: begin
                // Swap the key in hand with the occupant of the picked candidate.
                w_mem_we    = 1'b1;
                w_mem_waddr = w_pick_slot;
                n_lfsr      = w_lfsr_nx;
                n_key       = r_old_key[w_pick];
                n_choices   = r_old_ch[w_pick];
                n_attempt   = r_attempt + 8'd1;
                n_ci        = 2'd0;
                n_state     = S_ATTEMPT;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_SWEEP;
            r_sweep_idx    <= '0;
            r_clr_reply    <= 1'b0;
            r_failed       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_num_choices  <= NUM_CHOICES_RST;
            r_max_attempts <= MAX_ATTEMPTS_RST;
            r_lfsr         <= RANDOM_SEED_RST;
        end else begin
            r_state     <= n_state;
            r_sweep_idx <= n_sweep_idx;
            r_clr_reply <= n_clr_reply;
            r_failed    <= n_failed;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            // A seed write reloads the LFSR; a zero seed loads one.
            if (i_cfg_we && (i_cfg_idx == CFG_RANDOM_SEED)) begin
                r_lfsr <= (i_cfg_wdata == 32'd0) ? 32'd1 : i_cfg_wdata;
            end else begin
                r_lfsr <= n_lfsr;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_CHOICES: begin
                        r_num_choices <= i_cfg_wdata[2:0];
                    end
                    CFG_MAX_ATTEMPTS: begin
                        r_max_attempts <= i_cfg_wdata[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_choices <= n_choices;
        r_attempt <= n_attempt;
        r_ci      <= n_ci;
        r_out     <= n_out;
        if (w_save_old) begin
            r_old_key[r_ci] <= r_mem_q.key;
            r_old_ch[r_ci]  <= r_mem_q.choices;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_mem_raddr];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire
